// File: rtl/core/sopo_pkg.sv
// Shared types and constants for the segment perpendicular offset points unit.
// No dependencies; every module of the unit imports this package.
`timescale 1ns / 1ps
package sopo_pkg;

   localparam int COORD_W        = 32;
   localparam int OFFSET_W       = 24;
   localparam int NORM_W         = 31;
   localparam int ROOT_W         = 32;
   localparam int SQRT_STAGES    = 32;
   localparam int DIV_STAGES     = 24;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 24'd65536;

   // Side information that travels with a segment through the arithmetic pipeline.
   typedef struct packed {
      logic [COORD_W-1:0] mid_x;
      logic [COORD_W-1:0] mid_y;
      logic               neg_x;
      logic               neg_y;
      logic               zero;
   } side_type;

   // One classified segment handed from the front to the back.
   typedef struct packed {
      side_type          side;
      logic [NORM_W-1:0] abs_x;
      logic [NORM_W-1:0] abs_y;
   } item_type;

endpackage

// File: rtl/core/sopo_front.sv
// Front end: accepts segment beats, forms midpoint and normalized direction magnitudes.
// Depends on sopo_pkg.
`timescale 1ns / 1ps
module sopo_front
   import sopo_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   output logic                      q_push,
   output item_type                  q_item,
   input  logic                      q_ready
);

   logic              valid_ff, valid_in;
   logic [COORD_W-1:0] mid_x_ff, mid_y_ff;
   logic              neg_x_ff, neg_y_ff;
   logic [COORD_W:0]  abs_x_ff, abs_y_ff;

   logic              accept;
   logic [COORD_W:0]  sum_x, sum_y, dir_x, dir_y, mag;
   logic [5:0]        msb;
   logic [COORD_W:0]  sh_x, sh_y;

   assign full     = valid_ff && !q_ready;
   assign accept   = push && !full;
   assign q_push   = valid_ff && q_ready;
   assign valid_in = accept || (valid_ff && !q_ready);

   assign sum_x = {req_start_x[COORD_W-1], req_start_x} + {req_end_x[COORD_W-1], req_end_x};
   assign sum_y = {req_start_y[COORD_W-1], req_start_y} + {req_end_y[COORD_W-1], req_end_y};
   assign dir_x = {req_end_x[COORD_W-1], req_end_x} - {req_start_x[COORD_W-1], req_start_x};
   assign dir_y = {req_end_y[COORD_W-1], req_end_y} - {req_start_y[COORD_W-1], req_start_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         // Floor of half the sum is the arithmetic shift of the 33-bit sum.
         mid_x_ff <= sum_x[COORD_W:1];
         mid_y_ff <= sum_y[COORD_W:1];
         neg_x_ff <= !dir_y[COORD_W] && (dir_y != '0);
         neg_y_ff <= dir_x[COORD_W];
         abs_x_ff <= dir_x[COORD_W] ? (~dir_x + 1'b1) : dir_x;
         abs_y_ff <= dir_y[COORD_W] ? (~dir_y + 1'b1) : dir_y;
      end
   end

   // Scale both magnitudes so that the larger one has its top bit at position 30.
   assign mag = (abs_x_ff > abs_y_ff) ? abs_x_ff : abs_y_ff;

   always_comb begin
      msb = '0;
      for (int i = 0; i <= COORD_W; i++) begin
         if (mag[i]) begin
            msb = 6'(i);
         end
      end
   end

   always_comb begin
      if (msb < 6'(NORM_W - 1)) begin
         sh_x = abs_x_ff << (6'(NORM_W - 1) - msb);
         sh_y = abs_y_ff << (6'(NORM_W - 1) - msb);
      end else begin
         sh_x = abs_x_ff >> (msb - 6'(NORM_W - 1));
         sh_y = abs_y_ff >> (msb - 6'(NORM_W - 1));
      end
   end

   always_comb begin
      q_item.side.mid_x = mid_x_ff;
      q_item.side.mid_y = mid_y_ff;
      q_item.side.neg_x = neg_x_ff;
      q_item.side.neg_y = neg_y_ff;
      q_item.side.zero  = (mag == '0);
      q_item.abs_x      = sh_x[NORM_W-1:0];
      q_item.abs_y      = sh_y[NORM_W-1:0];
   end

endmodule

// File: rtl/core/sopo_queue.sv
// Small first-in first-out queue that decouples the front from the back.
// Depends on sopo_pkg.
`timescale 1ns / 1ps
module sopo_queue
   import sopo_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_push,
   input  item_type wr_item,
   output logic     wr_full,
   input  logic     rd_pop,
   output item_type rd_item,
   output logic     rd_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             do_wr, do_rd;

   assign wr_full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign do_wr    = wr_push && !wr_full;
   assign do_rd    = rd_pop && rd_valid;
   assign rd_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(DEPTH))
      else $error("queue count beyond depth");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      do_wr && !do_rd |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on write");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_pop |-> rd_valid)
      else $error("back popped an empty queue");

endmodule

// File: rtl/core/sopo_back.sv
// Back end: square root of the squared length, two rounding dividers, signs and saturation.
// Depends on sopo_pkg.
`timescale 1ns / 1ps
module sopo_back
   import sopo_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  item_type            q_item,
   output logic                q_pop,
   input  logic [OFFSET_W-1:0] offset,
   output logic                empty,
   input  logic                pop,
   output logic [COORD_W-1:0]  rsp_left_x,
   output logic [COORD_W-1:0]  rsp_left_y,
   output logic [COORD_W-1:0]  rsp_right_x,
   output logic [COORD_W-1:0]  rsp_right_y
);

   localparam int SQ_W  = 2 * NORM_W;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int PR_W  = NORM_W + OFFSET_W;
   localparam int NUM_W = PR_W + 1;

   function automatic logic [COORD_W-1:0] sat(input logic [COORD_W+1:0] v);
      if (v[COORD_W+1:COORD_W-1] == '0 || v[COORD_W+1:COORD_W-1] == '1) begin
         return v[COORD_W-1:0];
      end
      return v[COORD_W+1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
   endfunction

   logic adv;
   logic out_valid_ff;

   // The whole pipeline moves together; it holds only while a result waits unclaimed.
   assign adv   = !out_valid_ff || pop;
   assign q_pop = adv && q_valid;
   assign empty = !out_valid_ff;

   // Products stage.
   logic            p0_v_ff;
   side_type        p0_side_ff;
   logic [SQ_W-1:0] p0_aa_ff, p0_bb_ff;
   logic [PR_W-1:0] p0_bd_ff, p0_ad_ff;
   // Sum of squares stage.
   logic              p1_v_ff;
   side_type          p1_side_ff;
   logic [SQ_W:0]     p1_sq_ff;
   logic [PR_W-1:0]   p1_bd_ff, p1_ad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
      end else if (adv) begin
         p0_v_ff <= q_valid;
         p1_v_ff <= p0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_side_ff <= q_item.side;
         p0_aa_ff   <= q_item.abs_x * q_item.abs_x;
         p0_bb_ff   <= q_item.abs_y * q_item.abs_y;
         p0_bd_ff   <= q_item.abs_y * offset;
         p0_ad_ff   <= q_item.abs_x * offset;
         p1_side_ff <= p0_side_ff;
         p1_sq_ff   <= {1'b0, p0_aa_ff} + {1'b0, p0_bb_ff};
         p1_bd_ff   <= p0_bd_ff;
         p1_ad_ff   <= p0_ad_ff;
      end
   end

   // Square root, one result bit per stage.
   logic [SQRT_STAGES-1:0] sr_v_ff;
   logic [ROOT_W:0]        sr_rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0]      sr_root_ff [SQRT_STAGES];
   logic [RAD_W-1:0]       sr_rad_ff  [SQRT_STAGES];
   side_type               sr_side_ff [SQRT_STAGES];
   logic [PR_W-1:0]        sr_bd_ff   [SQRT_STAGES];
   logic [PR_W-1:0]        sr_ad_ff   [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      logic              v_src;
      logic [ROOT_W:0]   rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [RAD_W-1:0]  rad_src;
      side_type          side_src;
      logic [PR_W-1:0]   bd_src, ad_src;
      logic [ROOT_W+2:0] trial, sub;
      logic              ge;

      if (k == 0) begin : g_first
         assign v_src    = p1_v_ff;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = {{(RAD_W-SQ_W-1){1'b0}}, p1_sq_ff};
         assign side_src = p1_side_ff;
         assign bd_src   = p1_bd_ff;
         assign ad_src   = p1_ad_ff;
      end else begin : g_next
         assign v_src    = sr_v_ff[k-1];
         assign rem_src  = sr_rem_ff[k-1];
         assign root_src = sr_root_ff[k-1];
         assign rad_src  = sr_rad_ff[k-1];
         assign side_src = sr_side_ff[k-1];
         assign bd_src   = sr_bd_ff[k-1];
         assign ad_src   = sr_ad_ff[k-1];
      end

      assign trial = {rem_src, rad_src[RAD_W-1-2*k -: 2]};
      assign sub   = {1'b0, root_src, 2'b01};
      assign ge    = (trial >= sub);

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_v_ff[k] <= 1'b0;
         end else if (adv) begin
            sr_v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sr_rem_ff[k]  <= ge ? (ROOT_W+1)'(trial - sub) : trial[ROOT_W:0];
            sr_root_ff[k] <= {root_src[ROOT_W-2:0], ge};
            sr_rad_ff[k]  <= rad_src;
            sr_side_ff[k] <= side_src;
            sr_bd_ff[k]   <= bd_src;
            sr_ad_ff[k]   <= ad_src;
         end
      end
   end

   // Rounding numerators: product plus half the length.
   logic              nm_v_ff;
   side_type          nm_side_ff;
   logic [ROOT_W-1:0] nm_len_ff;
   logic [NUM_W-1:0]  nm_x_ff, nm_y_ff;
   logic [ROOT_W-1:0] len_w;

   assign len_w = sr_root_ff[SQRT_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_v_ff <= 1'b0;
      end else if (adv) begin
         nm_v_ff <= sr_v_ff[SQRT_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_side_ff <= sr_side_ff[SQRT_STAGES-1];
         nm_len_ff  <= len_w;
         nm_x_ff    <= {1'b0, sr_bd_ff[SQRT_STAGES-1]} + NUM_W'(len_w >> 1);
         nm_y_ff    <= {1'b0, sr_ad_ff[SQRT_STAGES-1]} + NUM_W'(len_w >> 1);
      end
   end

   // Two restoring dividers side by side, one quotient bit per stage.
   logic [DIV_STAGES-1:0] dv_v_ff;
   side_type              dv_side_ff [DIV_STAGES];
   logic [ROOT_W-1:0]     dv_len_ff  [DIV_STAGES];
   logic [ROOT_W-1:0]     dv_rx_ff   [DIV_STAGES];
   logic [ROOT_W-1:0]     dv_ry_ff   [DIV_STAGES];
   logic [DIV_STAGES-1:0] dv_qx_ff   [DIV_STAGES];
   logic [DIV_STAGES-1:0] dv_qy_ff   [DIV_STAGES];
   logic [DIV_STAGES-1:0] dv_nx_ff   [DIV_STAGES];
   logic [DIV_STAGES-1:0] dv_ny_ff   [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      logic                  v_src;
      side_type              side_src;
      logic [ROOT_W-1:0]     len_src, rx_src, ry_src;
      logic [DIV_STAGES-1:0] qx_src, qy_src, nx_src, ny_src;
      logic [ROOT_W:0]       tx, ty;
      logic                  gx, gy;

      if (j == 0) begin : g_first
         assign v_src    = nm_v_ff;
         assign side_src = nm_side_ff;
         assign len_src  = nm_len_ff;
         assign rx_src   = nm_x_ff[NUM_W-1:DIV_STAGES];
         assign ry_src   = nm_y_ff[NUM_W-1:DIV_STAGES];
         assign qx_src   = '0;
         assign qy_src   = '0;
         assign nx_src   = nm_x_ff[DIV_STAGES-1:0];
         assign ny_src   = nm_y_ff[DIV_STAGES-1:0];
      end else begin : g_next
         assign v_src    = dv_v_ff[j-1];
         assign side_src = dv_side_ff[j-1];
         assign len_src  = dv_len_ff[j-1];
         assign rx_src   = dv_rx_ff[j-1];
         assign ry_src   = dv_ry_ff[j-1];
         assign qx_src   = dv_qx_ff[j-1];
         assign qy_src   = dv_qy_ff[j-1];
         assign nx_src   = dv_nx_ff[j-1];
         assign ny_src   = dv_ny_ff[j-1];
      end

      assign tx = {rx_src, nx_src[DIV_STAGES-1-j]};
      assign ty = {ry_src, ny_src[DIV_STAGES-1-j]};
      assign gx = (tx >= {1'b0, len_src});
      assign gy = (ty >= {1'b0, len_src});

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_side_ff[j] <= side_src;
            dv_len_ff[j]  <= len_src;
            dv_rx_ff[j]   <= gx ? ROOT_W'(tx - {1'b0, len_src}) : tx[ROOT_W-1:0];
            dv_ry_ff[j]   <= gy ? ROOT_W'(ty - {1'b0, len_src}) : ty[ROOT_W-1:0];
            dv_qx_ff[j]   <= {qx_src[DIV_STAGES-2:0], gx};
            dv_qy_ff[j]   <= {qy_src[DIV_STAGES-2:0], gy};
            dv_nx_ff[j]   <= nx_src;
            dv_ny_ff[j]   <= ny_src;
         end
      end
   end

   // Signs, midpoint sums and saturation into the result register.
   side_type           fin_side;
   logic [COORD_W+1:0] off_x, off_y, mid_x, mid_y;
   logic [COORD_W+1:0] mag_x, mag_y;

   assign fin_side = dv_side_ff[DIV_STAGES-1];
   assign mag_x = fin_side.zero ? '0 : (COORD_W+2)'(dv_qx_ff[DIV_STAGES-1]);
   assign mag_y = fin_side.zero ? '0 : (COORD_W+2)'(dv_qy_ff[DIV_STAGES-1]);
   assign off_x = fin_side.neg_x ? (~mag_x + 1'b1) : mag_x;
   assign off_y = fin_side.neg_y ? (~mag_y + 1'b1) : mag_y;
   assign mid_x = {{2{fin_side.mid_x[COORD_W-1]}}, fin_side.mid_x};
   assign mid_y = {{2{fin_side.mid_y[COORD_W-1]}}, fin_side.mid_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_v_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_left_x  <= sat(mid_x + off_x);
         rsp_left_y  <= sat(mid_y + off_y);
         rsp_right_x <= sat(mid_x - off_x);
         rsp_right_y <= sat(mid_y - off_y);
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !pop |=> out_valid_ff && $stable(rsp_left_x) && $stable(rsp_right_y))
      else $error("waiting result changed before it was taken");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_v_ff) && $stable(sr_v_ff))
      else $error("pipeline moved while stalled");

   a_pop_only_when_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> adv && q_valid)
      else $error("queue popped while back end stalled");

endmodule

// File: rtl/core/segment_perpendicular_offset_points_unit.sv
// Top level of the segment perpendicular offset points unit and its offset register.
// Depends on sopo_pkg, sopo_front, sopo_queue and sopo_back.
`timescale 1ns / 1ps
// This unit takes one path segment per beat, two points in signed Q15.16, and returns
// one result beat holding the two points that sit the configured offset distance to
// either side of the segment midpoint, perpendicular to the segment. A zero-length
// segment returns the midpoint twice, and every coordinate saturates to the signed
// 32-bit range. Both sides behave as queues: a segment is taken when push is high and
// full is low, and a result is taken when pop is high and empty is low. The unit takes
// one segment every cycle and delivers one result every cycle while the consumer keeps
// popping. An accepted segment passes through the front register, the queue, a
// multiply stage, a sum of squares stage, 32 square root stages (one root bit each),
// a numerator stage, 24 divider stages (one quotient bit each) and the result register
// on its way to the ports. The offset distance, unsigned Q8.16, resets to 1.0. The user
// must write it through csr_wr_en and csr_wr_data only while the unit is idle (not enforced).
module segment_perpendicular_offset_points_unit
   import sopo_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [COORD_W-1:0] rsp_left_x,
   output logic signed [COORD_W-1:0] rsp_left_y,
   output logic signed [COORD_W-1:0] rsp_right_x,
   output logic signed [COORD_W-1:0] rsp_right_y,
   input  logic                      csr_wr_en,
   input  logic [OFFSET_W-1:0]       csr_wr_data
);

   // The offset distance register; it must change only while no segment is in flight, which the block does not enforce.
   logic [OFFSET_W-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   // Front to queue.
   logic     fq_push, fq_full;
   item_type fq_item;
   // Queue to back.
   logic     qb_valid, qb_pop;
   item_type qb_item;

   // The front registers each segment, then scales the direction magnitudes so that
   // the larger has its top bit at position 30 before it enters the queue.
   sopo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .q_push      (fq_push),
      .q_item      (fq_item),
      .q_ready     (!fq_full)
   );

   // The queue lets the front keep taking beats while the back holds, until its QUEUE_DEPTH entries are full.
   sopo_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (fq_push),
      .wr_item  (fq_item),
      .wr_full  (fq_full),
      .rd_pop   (qb_pop),
      .rd_item  (qb_item),
      .rd_valid (qb_valid)
   );

   // The back computes the length, the two rounded offset magnitudes and the results.
   sopo_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (qb_valid),
      .q_item      (qb_item),
      .q_pop       (qb_pop),
      .offset      (offset_ff),
      .empty       (empty),
      .pop         (pop),
      .rsp_left_x  (rsp_left_x),
      .rsp_left_y  (rsp_left_y),
      .rsp_right_x (rsp_right_x),
      .rsp_right_y (rsp_right_y)
   );

endmodule

// File: tb/tb_segment_perpendicular_offset_points_unit.sv
// Self-checking testbench for the segment perpendicular offset points unit.
// Depends on sopo_pkg and segment_perpendicular_offset_points_unit.
`timescale 1ns / 1ps
module tb_segment_perpendicular_offset_points_unit;
   import sopo_pkg::*;

   // Extra wait after the last predicted result has arrived, before drain returns.
   localparam int DRAIN_CYCLES = 120;
   // The longest quiet stretch is the receiver hold-off plus pipeline latency.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [COORD_W-1:0] left_x;
      logic [COORD_W-1:0] left_y;
      logic [COORD_W-1:0] right_x;
      logic [COORD_W-1:0] right_y;
   } points_type;

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic signed [COORD_W-1:0] req_start_x;
   logic signed [COORD_W-1:0] req_start_y;
   logic signed [COORD_W-1:0] req_end_x;
   logic signed [COORD_W-1:0] req_end_y;
   logic empty;
   logic pop;
   logic signed [COORD_W-1:0] rsp_left_x;
   logic signed [COORD_W-1:0] rsp_left_y;
   logic signed [COORD_W-1:0] rsp_right_x;
   logic signed [COORD_W-1:0] rsp_right_y;
   logic csr_wr_en;
   logic [OFFSET_W-1:0] csr_wr_data;

   // Model copy of the offset register and the queue of predicted point pairs.
   logic [OFFSET_W-1:0] model_offset;
   points_type expected_points[$];
   int mismatches = 0;
   int beats_sent;
   int beats_checked = 0;
   int idle_cycles;
   int pop_gap;
   bit hold_consumer;
   bit pop_random;

   segment_perpendicular_offset_points_unit i_dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .empty(empty), .pop(pop),
      .rsp_left_x(rsp_left_x), .rsp_left_y(rsp_left_y),
      .rsp_right_x(rsp_right_x), .rsp_right_y(rsp_right_y),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bit-serial integer square root, floor of the root of a 64-bit value.
   function automatic logic [63:0] floor_root(logic [63:0] value);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem = value;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[COORD_W-1:0];
   endfunction

   // Predicts the two offset points for one segment under the current offset.
   function automatic points_type offset_points(logic signed [COORD_W-1:0] sx,
         logic signed [COORD_W-1:0] sy, logic signed [COORD_W-1:0] ex,
         logic signed [COORD_W-1:0] ey);
      logic signed [63:0] mx;
      logic signed [63:0] my;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [63:0] ox;
      logic signed [63:0] oy;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] span;
      logic [63:0] len;
      logic [63:0] spacing;
      points_type pts;
      mx = (64'(sx) + 64'(ex)) >>> 1;
      my = (64'(sy) + 64'(ey)) >>> 1;
      dx = 64'(ex) - 64'(sx);
      dy = 64'(ey) - 64'(sy);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      span = ax > ay ? ax : ay;
      ox = 0;
      oy = 0;
      if (span != 0) begin
         while (span < (64'd1 << 30)) begin
            ax = ax << 1; ay = ay << 1; span = span << 1;
         end
         while (span >= (64'd1 << 31)) begin
            ax = ax >> 1; ay = ay >> 1; span = span >> 1;
         end
         len = floor_root(ax * ax + ay * ay);
         spacing = 64'(model_offset);
         ox = $signed((ay * spacing + (len >> 1)) / len);
         oy = $signed((ax * spacing + (len >> 1)) / len);
         if (dy > 0) ox = -ox;
         if (dx < 0) oy = -oy;
      end
      pts.left_x = clamp_coord(mx + ox);
      pts.left_y = clamp_coord(my + oy);
      pts.right_x = clamp_coord(mx - ox);
      pts.right_y = clamp_coord(my - oy);
      return pts;
   endfunction

   // Sends one segment beat, optionally after a random gap, waiting for the queue to have room.
   task automatic send_segment(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
         logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey, int allow_gap);
      int gap;
      if (allow_gap != 0 && $urandom_range(0, 3) == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      @(posedge clock);
      while (full) @(posedge clock);
      expected_points.push_back(offset_points(sx, sy, ex, ey));
      beats_sent++;
   endtask

   task automatic end_burst();
      push <= 1'b0;
   endtask

   // Ends the burst and waits until every predicted result has arrived and the extra drain wait has passed.
   task automatic drain();
      end_burst();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(logic [OFFSET_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_offset = value;
   endtask

   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return $urandom_range(0, 2000) - 1000;
         default: return ($urandom() >> $urandom_range(0, 30)) * ($urandom_range(0, 1) ? 1 : -1);
      endcase
   endfunction

   // Directed segments: extremes, axis-aligned in all four directions, zero length.
   task automatic test_directed();
      send_segment(0, 0, 0, 0, 0);
      send_segment(32'h1234_5678, -32'sd77, 32'h1234_5678, -32'sd77, 0);
      send_segment(0, 0, 32'h0001_0000, 0, 0);
      send_segment(0, 0, -32'sh0001_0000, 0, 0);
      send_segment(0, 0, 0, 32'h0001_0000, 0);
      send_segment(0, 0, 0, -32'sh0001_0000, 0);
      send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FF00, 0);
      send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0100, 32'h8000_0000, 0);
      send_segment(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 1, 0);
      send_segment(-32'sd1, -32'sd1, 0, 0, 0);
      send_segment(1, 0, 0, 1, 0);
      send_segment(0, 0, 3, 4, 0);
      send_segment(32'h0003_0000, 32'h0004_0000, 0, 0, 0);
      send_segment(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 0);
      drain();
   endtask

   task automatic test_random(int count);
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      for (int n = 0; n < count; n++) begin
         sx = random_coord();
         sy = random_coord();
         if ($urandom_range(0, 19) == 0)
            send_segment(sx, sy, sx, sy, 1);
         else
            send_segment(sx, sy, random_coord(), random_coord(), 1);
      end
      drain();
   endtask

   // Consumer stops popping for a long stretch while segments keep coming.
   task automatic test_backpressure();
      hold_consumer = 1'b1;
      fork
         repeat (HOLD_CYCLES) @(posedge clock);
         for (int n = 0; n < 100; n++) send_segment(random_coord(), random_coord(),
               random_coord(), random_coord(), 0);
      join_any
      hold_consumer = 1'b0;
      wait fork;
      drain();
   endtask

   task automatic test_offsets();
      logic [OFFSET_W-1:0] settings[5] = '{24'd0, 24'hFF_FFFF, 24'd1, 24'h00_8000, 24'h12_3456};
      foreach (settings[k]) begin
         write_offset(settings[k]);
         test_random(150);
      end
      write_offset(OFFSET_W'($urandom()));
      test_directed();
      write_offset(24'hFF_FFFF);
      test_directed();
   endtask

   // Pop driver: random stalls, mostly short with an occasional long one, stretches of
   // steady popping, and a forced hold when asked.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_random <= 1'b1;
         pop_gap <= 0;
      end else if (hold_consumer) begin
         pop <= 1'b0;
      end else if (pop_gap != 0) begin
         pop <= 1'b0;
         pop_gap <= pop_gap - 1;
      end else if (pop_random) begin
         pop <= ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 40) == 0) pop_gap <= $urandom_range(10, 40);
         if ($urandom_range(0, 200) == 0) pop_random <= 1'b0;
      end else begin
         pop <= 1'b1;
         if ($urandom_range(0, 100) == 0) pop_random <= 1'b1;
      end
   end

   // Result checker and watchdog. Each popped beat is compared with the oldest prediction.
   always @(posedge clock) begin
      points_type want;
      points_type got;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", expected_points.size());
            $display("FAILURE");
            $finish;
         end
         if (pop && !empty) begin
            got = {rsp_left_x, rsp_left_y, rsp_right_x, rsp_right_y};
            if (expected_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result beat %h.", got);
            end else begin
               want = expected_points.pop_front();
               beats_checked++;
               if (want !== got) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected L(%h,%h) R(%h,%h) got L(%h,%h) R(%h,%h).",
                        want.left_x, want.left_y, want.right_x, want.right_y,
                        got.left_x, got.left_y, got.right_x, got.right_y);
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x = '0;
      req_end_y = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      model_offset = OFFSET_RESET;
      beats_sent = 0;
      hold_consumer = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600);
      test_backpressure();
      test_offsets();
      $display("Sent %0d segments and checked %0d result beats over several offset settings,",
         beats_sent, beats_checked);
      $display("including directed extremes, zero-length segments and a long consumer stall.");
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: segment_perpendicular_offset_points_unit.f
rtl/core/sopo_pkg.sv
rtl/core/sopo_front.sv
rtl/core/sopo_queue.sv
rtl/core/sopo_back.sv
rtl/core/segment_perpendicular_offset_points_unit.sv
tb/tb_segment_perpendicular_offset_points_unit.sv
